[rtl/fpss_pkg.sv]
// Shared types and constants of the five-point stencil smoother.
// Depends on nothing; every other file but fpss_ram imports it.
`default_nettype none

package fpss_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_SIDE_DEF    = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed register widths.
  localparam int GAIN_W     = 16;
  localparam int SIDE_CFG_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Reset values of the registers.
  localparam int                       SIDE_RST  = 1024;
  localparam logic signed [GAIN_W-1:0] NGAIN_RST = 16'sd3277;
  localparam logic signed [GAIN_W-1:0] CGAIN_RST = 16'sd13107;

  // Smallest grid side that has an interior.
  localparam int SIDE_MIN = 3;

  // Q1.15 products carry 30 fractional bits; round at bit 14.
  localparam int FRAC_BITS  = 15;
  localparam int ROUND_BIAS = 16384;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIDE     = 2'd0,
    CFG_NEIGHBOR_GAIN = 2'd1,
    CFG_CENTER_GAIN   = 2'd2
  } cfg_reg_t;

  // Control tag of an accepted word, worked out from the raster position.
  typedef struct packed {
    logic first_col;  // column 0: centre comes from the row head register
    logic emit;       // interior point, gives a result
    logic last;       // final interior point of the grid
  } tag_t;

endpackage

`default_nettype wire

[rtl/fpss_in_if.sv]
// Input channel of the smoother: valid/ready handshake and one sample.
// Depends on fpss_pkg for the default sample width.
`default_nettype none

interface fpss_in_if
  import fpss_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

[rtl/fpss_out_if.sv]
// Result channel of the smoother: valid/ready handshake, smoothed value and end-of-grid flag.
// Depends on fpss_pkg for the default sample width.
`default_nettype none

interface fpss_out_if
  import fpss_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] smoothed;
  logic                          last_of_grid;

  modport source (output valid, output smoothed, output last_of_grid, input ready);
  modport sink   (input valid, input smoothed, input last_of_grid, output ready);
endinterface

`default_nettype wire

[rtl/five_point_stencil_smoother_unit.sv]
// Five-point stencil smoother: takes one grid sample a cycle while ready is high, in raster
// order, and gives neighbour_gain * (up + down + left + right) + center_gain * centre for
// each interior point, rounded to nearest and saturated to Q1.15. A result passes stage 1,
// stage 2 and the output register after the sample on the row below it is accepted. The rate
// is set by the two row stores, each of which does one read and one write a cycle. The output
// holds one result register and one skid word; input ready drops only while both are full.
// The row stores come out of reset with unknown contents and need no clearing pass, since a
// result only reads rows of the current grid. Writing grid_side restarts the grid at the next
// sample. The user must write configuration only while idle; the block does not enforce it.
// Depends on fpss_pkg, fpss_in_if, fpss_out_if, fpss_ram, fpss_raster, fpss_calc, fpss_skid.
`default_nettype none

module five_point_stencil_smoother_unit
  import fpss_pkg::*;
#(
  parameter int MAX_SIDE    = MAX_SIDE_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  fpss_in_if.sink                    in_ch,
  fpss_out_if.source                 out_ch
);

  localparam int POS_W = $clog2(MAX_SIDE);

  logic                          en;
  logic                          stall;
  logic                          in_acc;
  logic [POS_W-1:0]              col;
  tag_t                          acc_tag;
  logic                          restart;
  logic signed [GAIN_W-1:0]      ngain;
  logic signed [GAIN_W-1:0]      cgain;
  logic signed [SAMPLE_BITS-1:0] top_rd;
  logic signed [SAMPLE_BITS-1:0] right_rd;
  logic                          up_we;
  logic [POS_W-1:0]              up_waddr;
  logic signed [SAMPLE_BITS-1:0] up_wdata;
  logic                          push_v;
  logic signed [SAMPLE_BITS-1:0] push_smoothed;
  logic                          push_last;

  // The whole pipeline moves unless the skid word is occupied.
  assign en          = !stall;
  assign in_ch.ready = en;
  assign in_acc      = in_ch.valid && en;

  fpss_raster #(
    .MAX_SIDE (MAX_SIDE),
    .POS_W    (POS_W)
  ) u_raster (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_acc    (in_acc),
    .col       (col),
    .tag       (acc_tag),
    .restart   (restart),
    .ngain     (ngain),
    .cgain     (cgain)
  );

  // Upper row: read at the current column, written back from stage 1.
  fpss_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_SIDE)
  ) u_upper_row (
    .clk   (clk),
    .we    (up_we),
    .waddr (up_waddr),
    .wdata (up_wdata),
    .re    (in_acc),
    .raddr (col),
    .rdata (top_rd)
  );

  // Middle row: the right neighbour is read one column ahead, the new sample written in place.
  fpss_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_SIDE)
  ) u_middle_row (
    .clk   (clk),
    .we    (in_acc),
    .waddr (col),
    .wdata (in_ch.sample),
    .re    (in_acc),
    .raddr (col + 1'b1),
    .rdata (right_rd)
  );

  fpss_calc #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .POS_W       (POS_W)
  ) u_calc (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .restart       (restart),
    .in_acc        (in_acc),
    .col           (col),
    .tag           (acc_tag),
    .sample        (in_ch.sample),
    .ngain         (ngain),
    .cgain         (cgain),
    .top_rd        (top_rd),
    .right_rd      (right_rd),
    .up_we         (up_we),
    .up_waddr      (up_waddr),
    .up_wdata      (up_wdata),
    .push_v        (push_v),
    .push_smoothed (push_smoothed),
    .push_last     (push_last)
  );

  fpss_skid #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_skid (
    .clk           (clk),
    .rst_n         (rst_n),
    .push_v        (push_v),
    .push_smoothed (push_smoothed),
    .push_last     (push_last),
    .stall         (stall),
    .out_ch        (out_ch)
  );

`ifndef SYNTHESIS
  // A full skid word implies the output register also holds a word.
  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with no result waiting");

  // The first column is a border point and never gives a result.
  a_first_col_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && acc_tag.first_col |-> !acc_tag.emit)
    else $error("border column tagged for a result");

  // Writing the grid side restarts the raster at column zero.
  a_side_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == CFG_GRID_SIDE) |=> (col == '0))
    else $error("grid side write did not restart the raster");
`endif

endmodule

`default_nettype wire

[rtl/fpss_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`default_nettype none

module fpss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/fpss_raster.sv]
// Configuration registers and raster position counters of the smoother.
// Depends on fpss_pkg; tags every accepted word with its place in the grid.
`default_nettype none

module fpss_raster
  import fpss_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  parameter int POS_W    = $clog2(MAX_SIDE)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                     in_acc,
  output      logic [POS_W-1:0]         col,
  output      tag_t                     tag,
  output      logic                     restart,
  output      logic signed [GAIN_W-1:0] ngain,
  output      logic signed [GAIN_W-1:0] cgain
);

  // Reset side, clamped to the supported range.
  localparam int RST_SIDE    = (SIDE_RST > MAX_SIDE) ? MAX_SIDE : SIDE_RST;
  localparam int RST_SIDE_M1 = RST_SIDE - 1;

  logic [POS_W-1:0]         col_r, col_nxt;
  logic [POS_W-1:0]         row_r, row_nxt;
  logic [POS_W-1:0]         side_m1_r, side_m1_nxt;
  logic signed [GAIN_W-1:0] ngain_r, ngain_nxt;
  logic signed [GAIN_W-1:0] cgain_r, cgain_nxt;
  logic [31:0]              side_req;
  logic [31:0]              side_clamped;
  logic                     side_wr;

  // Clamp a requested side to the range the stores can hold.
  always_comb begin
    side_req = 32'(cfg_wdata[SIDE_CFG_W-1:0]);
    if (side_req < 32'(SIDE_MIN)) begin
      side_clamped = 32'(SIDE_MIN);
    end else if (side_req > 32'(MAX_SIDE)) begin
      side_clamped = 32'(MAX_SIDE);
    end else begin
      side_clamped = side_req;
    end
  end

  // Register writes and position advance.
  always_comb begin
    side_m1_nxt = side_m1_r;
    ngain_nxt   = ngain_r;
    cgain_nxt   = cgain_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    side_wr     = 1'b0;

    if (in_acc) begin
      if (col_r == side_m1_r) begin
        col_nxt = '0;
        row_nxt = (row_r == side_m1_r) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end

    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_GRID_SIDE: begin
          side_wr     = 1'b1;
          side_m1_nxt = POS_W'(side_clamped - 32'd1);
          col_nxt     = '0;
          row_nxt     = '0;
        end
        CFG_NEIGHBOR_GAIN: begin
          ngain_nxt = cfg_wdata;
        end
        CFG_CENTER_GAIN: begin
          cgain_nxt = cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      side_m1_r <= POS_W'(RST_SIDE_M1);
      ngain_r   <= NGAIN_RST;
      cgain_r   <= CGAIN_RST;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      side_m1_r <= side_m1_nxt;
      ngain_r   <= ngain_nxt;
      cgain_r   <= cgain_nxt;
    end
  end

  // Tag of the word at the current position.
  always_comb begin
    tag.first_col = (col_r == '0);
    tag.emit      = (row_r > POS_W'(1)) && (col_r != '0) && (col_r != side_m1_r);
    tag.last      = (row_r == side_m1_r) && (col_r == side_m1_r - 1'b1);
  end

  assign col     = col_r;
  assign restart = side_wr;
  assign ngain   = ngain_r;
  assign cgain   = cgain_r;

endmodule

`default_nettype wire

[rtl/fpss_calc.sv]
// Stencil datapath: taps and row-head register, upper row write-back, gain products,
// rounding and saturation. Depends on fpss_pkg.
`default_nettype none

module fpss_calc
  import fpss_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int POS_W       = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          restart,
  input  wire logic                          in_acc,
  input  wire logic [POS_W-1:0]              col,
  input  wire tag_t                          tag,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic signed [GAIN_W-1:0]      ngain,
  input  wire logic signed [GAIN_W-1:0]      cgain,
  input  wire logic signed [SAMPLE_BITS-1:0] top_rd,
  input  wire logic signed [SAMPLE_BITS-1:0] right_rd,
  output      logic                          up_we,
  output      logic [POS_W-1:0]              up_waddr,
  output      logic signed [SAMPLE_BITS-1:0] up_wdata,
  output      logic                          push_v,
  output      logic signed [SAMPLE_BITS-1:0] push_smoothed,
  output      logic                          push_last
);

  localparam int W      = SAMPLE_BITS;
  localparam int NSUM_W = W + 2;
  localparam int PN_W   = NSUM_W + GAIN_W;
  localparam int PC_W   = W + GAIN_W;
  localparam int ACC_W  = W + 19;
  localparam int RND_W  = ACC_W - FRAC_BITS;
  localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] SAT_MIN = -SAT_MAX - RND_W'(1);

  // Stage 1: word waiting for its store reads.
  logic                 s1_v_r;
  tag_t                 s1_tag_r;
  logic [POS_W-1:0]     s1_col_r;
  logic signed [W-1:0]  s1_sample_r;

  // Taps of the middle row and the first sample of the last row.
  logic signed [W-1:0]  left_tap_r, left_tap_nxt;
  logic signed [W-1:0]  center_tap_r, center_tap_nxt;
  logic signed [W-1:0]  row_head_r, row_head_nxt;

  // Stage 2: registered products.
  logic                 s2_v_r;
  logic                 s2_last_r;
  logic signed [PN_W-1:0] prod_n_r;
  logic signed [PC_W-1:0] prod_c_r;

  logic signed [W-1:0]      left, center;
  logic signed [NSUM_W-1:0] nsum;
  logic signed [PN_W-1:0]   prod_n_nxt;
  logic signed [PC_W-1:0]   prod_c_nxt;
  logic                     s1_go;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [RND_W-1:0]  rnd;

  assign s1_go = en && s1_v_r;

  // Neighbourhood of the point one row up from the incoming word.
  always_comb begin
    if (s1_tag_r.first_col) begin
      left   = '0;
      center = row_head_r;
    end else begin
      left   = left_tap_r;
      center = center_tap_r;
    end
    nsum = NSUM_W'(top_rd) + NSUM_W'(s1_sample_r) + NSUM_W'(left) + NSUM_W'(right_rd);
    prod_n_nxt = nsum * ngain;
    prod_c_nxt = center * cgain;
  end

  // Tap movement as the word passes stage 1.
  always_comb begin
    left_tap_nxt   = left_tap_r;
    center_tap_nxt = center_tap_r;
    row_head_nxt   = row_head_r;
    if (restart) begin
      left_tap_nxt   = '0;
      center_tap_nxt = '0;
    end else if (s1_go) begin
      left_tap_nxt   = center;
      center_tap_nxt = right_rd;
      if (s1_tag_r.first_col) begin
        row_head_nxt = s1_sample_r;
      end
    end
  end

  // The centre moves up into the upper row store.
  assign up_we    = s1_go;
  assign up_waddr = s1_col_r;
  assign up_wdata = center;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      left_tap_r   <= '0;
      center_tap_r <= '0;
      row_head_r   <= '0;
    end else begin
      left_tap_r   <= left_tap_nxt;
      center_tap_r <= center_tap_nxt;
      row_head_r   <= row_head_nxt;
      if (en) begin
        s1_v_r <= in_acc;
        s2_v_r <= s1_v_r && s1_tag_r.emit;
      end
    end
  end

  // Payload of the pipeline stages.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag_r    <= tag;
      s1_col_r    <= col;
      s1_sample_r <= sample;
      s2_last_r   <= s1_tag_r.last;
      prod_n_r    <= prod_n_nxt;
      prod_c_r    <= prod_c_nxt;
    end
  end

  // Sum of products, round to nearest (ties up) and saturate.
  always_comb begin
    acc     = ACC_W'(prod_n_r) + ACC_W'(prod_c_r);
    acc_rnd = acc + ACC_W'(ROUND_BIAS);
    rnd     = acc_rnd[ACC_W-1:FRAC_BITS];
    if (rnd > SAT_MAX) begin
      push_smoothed = SAT_MAX[W-1:0];
    end else if (rnd < SAT_MIN) begin
      push_smoothed = SAT_MIN[W-1:0];
    end else begin
      push_smoothed = rnd[W-1:0];
    end
  end

  assign push_v    = en && s2_v_r;
  assign push_last = s2_last_r;

endmodule

`default_nettype wire

[rtl/fpss_skid.sv]
// Output register with one skid word, so the pipeline keeps taking words while a result waits.
// Depends on fpss_pkg and the fpss_out_if interface.
`default_nettype none

module fpss_skid
  import fpss_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push_v,
  input  wire logic signed [SAMPLE_BITS-1:0] push_smoothed,
  input  wire logic                          push_last,
  output      logic                          stall,
  fpss_out_if.source                         out_ch
);

  logic                          out_v_r;
  logic signed [SAMPLE_BITS-1:0] out_smoothed_r;
  logic                          out_last_r;
  logic                          sk_v_r;
  logic signed [SAMPLE_BITS-1:0] sk_smoothed_r;
  logic                          sk_last_r;
  logic                          out_free;

  assign out_free = !out_v_r || out_ch.ready;

  // Valid flags of the output and skid words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (out_free) begin
      out_v_r <= sk_v_r || push_v;
      sk_v_r  <= 1'b0;
    end else if (push_v) begin
      sk_v_r  <= 1'b1;
    end
  end

  // Payload: the skid word goes first once the output frees up.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (sk_v_r) begin
        out_smoothed_r <= sk_smoothed_r;
        out_last_r     <= sk_last_r;
      end else begin
        out_smoothed_r <= push_smoothed;
        out_last_r     <= push_last;
      end
    end else if (push_v) begin
      sk_smoothed_r <= push_smoothed;
      sk_last_r     <= push_last;
    end
  end

  assign stall               = sk_v_r;
  assign out_ch.valid        = out_v_r;
  assign out_ch.smoothed     = out_smoothed_r;
  assign out_ch.last_of_grid = out_last_r;

endmodule

`default_nettype wire
